[rtl/mrdo_pkg.sv]
package mrdo_pkg;

	localparam int RING_BYTES_DEF   = 1024;
	localparam int MAX_MESSAGES_DEF = 1024;
	localparam int MAX_READ_DEF     = 64;

	localparam int LEN_W   = 11;
	localparam int LIMIT_W = 7;

	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_NOTHING = 2'd2;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic               first_byte;
		logic [LEN_W-1:0]   msg_len;
		logic [7:0]         data_byte;
		logic [LIMIT_W-1:0] read_limit;
	} item_t;

endpackage

[rtl/message_ring_drop_oldest_top.sv]
// Byte ring holding whole variable-length messages, dropping the oldest when
// a new one does not fit. Push words (cmd 0) carry one byte each; the first
// carries the length. A first word that opens a storable message first drops
// as many old messages as it needs, and each drop reads one descriptor from
// the descriptor memory. The last byte of a message returns one status word.
// A read word (cmd 1) returns whole oldest messages up to its byte limit: per
// message a descriptor read, then per data word a byte memory read and then
// output; a read that finds nothing returns one "nothing" word. A two-word
// input queue lets pushes land while the output register is stalled. No
// clearing pass after reset.
module message_ring_drop_oldest_top #(
	parameter int RING_BYTES   = mrdo_pkg::RING_BYTES_DEF,
	parameter int MAX_MESSAGES = mrdo_pkg::MAX_MESSAGES_DEF,
	parameter int MAX_READ     = mrdo_pkg::MAX_READ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic        first_byte,
	input  logic [10:0] msg_len,
	input  logic [7:0]  data_byte,
	input  logic [6:0]  read_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        message_end,
	output logic        rejected,
	output logic        dropped
);
	mrdo_pkg::item_t in_item, q_item;
	logic q_valid, q_pop;

	// port fields packed into one queue word
	assign in_item = '{cmd: cmd, first_byte: first_byte, msg_len: msg_len,
		data_byte: data_byte, read_limit: read_limit};

	mrdo_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	// engine: descriptor walk, drops, byte moves, output register
	mrdo_back #(
		.RING_BYTES(RING_BYTES), .MAX_MESSAGES(MAX_MESSAGES), .MAX_READ(MAX_READ)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .out_byte(out_byte), .last(last),
		.message_end(message_end), .rejected(rejected), .dropped(dropped)
	);
endmodule

[rtl/mrdo_front.sv]
module mrdo_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mrdo_pkg::item_t in_item,
	output logic           q_valid,
	input  logic           q_pop,
	output mrdo_pkg::item_t q_item
);
	// two-entry word queue between the port and the engine
	mrdo_pkg::item_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

[rtl/mrdo_back.sv]
module mrdo_back #(
	parameter int RING_BYTES   = mrdo_pkg::RING_BYTES_DEF,
	parameter int MAX_MESSAGES = mrdo_pkg::MAX_MESSAGES_DEF,
	parameter int MAX_READ     = mrdo_pkg::MAX_READ_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_pop,
	input  mrdo_pkg::item_t q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte,
	output logic            last,
	output logic            message_end,
	output logic            rejected,
	output logic            dropped
);
	localparam int RA  = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
	localparam int MA  = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
	localparam int UW  = $clog2(RING_BYTES + 1);
	localparam int CW  = $clog2(MAX_MESSAGES + 1);
	localparam int LW  = (UW > mrdo_pkg::LEN_W) ? UW : mrdo_pkg::LEN_W;
	localparam int TW  = ((UW > mrdo_pkg::LIMIT_W) ? UW : mrdo_pkg::LIMIT_W) + 1;
	localparam int DW  = RA + UW;
	localparam int LIMW = mrdo_pkg::LIMIT_W;

	typedef enum logic [3:0] {
		S_IDLE, S_ZSTAT, S_PFIRST, S_DROP, S_PBYTE,
		S_RHEAD, S_RCHK, S_RBYTE, S_ROUT, S_REND
	} state_t;

	state_t state_q;

	logic [7:0]    byte_mem [RING_BYTES];
	logic [DW-1:0] desc_mem [MAX_MESSAGES];
	logic [7:0]    byte_rd_q;
	logic [DW-1:0] desc_rd_q;

	mrdo_pkg::item_t it_q;
	logic [MA-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [RA-1:0] cursor_q, tail_q, rcur_q;
	logic [UW-1:0] used_q, plen_q, rrem_q;
	logic [LW-1:0] left_q;
	logic [1:0]    flags_q;
	logic [TW-1:0] total_q;
	logic [LIMW-1:0] limit_q;
	logic          pend_q;
	logic [7:0]    pbyte_q;

	logic       ov_q;
	logic [1:0] kind_q;
	logic [7:0] ob_q;
	logic       last_q, mend_q, rej_q, drp_q;

	logic          outfree;
	logic [LW-1:0] len_x;
	logic [UW-1:0] d_len;
	logic [RA-1:0] d_start;
	logic [MA-1:0] head_nx, slot;
	logic [CW:0]   slot_sum;
	logic [RA-1:0] cursor_nx, rcur_nx;
	logic          need_drop, wr_byte, wr_desc;
	logic [RA-1:0] new_start;
	logic [LW:0]   fit_sum;
	logic          rover, emit;

	assign outfree  = !ov_q || out_ready;
	assign len_x    = LW'(q_item.msg_len);
	assign d_start  = desc_rd_q[DW-1:UW];
	assign d_len    = desc_rd_q[UW-1:0];
	assign head_nx  = (head_q == MA'(MAX_MESSAGES - 1)) ? '0 : head_q + 1'b1;
	assign slot_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign slot     = (slot_sum >= (CW+1)'(MAX_MESSAGES)) ?
		MA'(slot_sum - (CW+1)'(MAX_MESSAGES)) : MA'(slot_sum);
	assign cursor_nx = (cursor_q == RA'(RING_BYTES - 1)) ? '0 : cursor_q + 1'b1;
	assign rcur_nx   = (rcur_q == RA'(RING_BYTES - 1)) ? '0 : rcur_q + 1'b1;
	assign fit_sum   = (LW+1)'(used_q) + (LW+1)'(it_q.msg_len);
	assign need_drop = ((count_q != '0) && (fit_sum > (LW+1)'(RING_BYTES)))
		|| (count_q >= CW'(MAX_MESSAGES));
	assign new_start = (count_q != '0) ? tail_q : '0;
	assign wr_desc   = (state_q == S_PFIRST) && !need_drop;
	assign wr_byte   = (state_q == S_PBYTE) && (left_q != '0) && !flags_q[0]
		&& ((left_q != LW'(1)) || outfree);
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	// head message does not fit in what is left of the read limit
	assign rover     = (total_q + TW'(d_len)) > TW'(limit_q);
	// output register loads a word this cycle
	assign emit      = outfree && ((state_q == S_ZSTAT)
		|| ((state_q == S_PBYTE) && (left_q == LW'(1)))
		|| ((state_q == S_RCHK) && !rover && pend_q)
		|| ((state_q == S_ROUT) && (rrem_q != UW'(1)))
		|| (state_q == S_REND));

	always_ff @(posedge clk) begin
		if (wr_desc) desc_mem[slot] <= {new_start, UW'(it_q.msg_len)};
		if (wr_byte) byte_mem[cursor_q] <= it_q.data_byte;
		desc_rd_q <= desc_mem[head_q];
		byte_rd_q <= byte_mem[rcur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			cursor_q <= '0;
			tail_q   <= '0;
			used_q   <= '0;
			left_q   <= '0;
			flags_q  <= '0;
			ov_q     <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q <= q_item;
						if (q_item.cmd == mrdo_pkg::CMD_READ) begin
							total_q <= '0;
							pend_q  <= 1'b0;
							limit_q <= (q_item.read_limit > LIMW'(MAX_READ)) ?
								LIMW'(MAX_READ) : q_item.read_limit;
							state_q <= S_RHEAD;
						end else if (q_item.first_byte) begin
							if (q_item.msg_len == '0) begin
								flags_q <= '0;
								left_q  <= '0;
								state_q <= S_ZSTAT;
							end else if ((LW+1)'(len_x) > (LW+1)'(RING_BYTES)) begin
								flags_q <= 2'b01;
								left_q  <= len_x;
								state_q <= S_PBYTE;
							end else begin
								flags_q <= '0;
								left_q  <= '0;
								state_q <= S_PFIRST;
							end
						end else begin
							state_q <= S_PBYTE;
						end
					end
				end
				S_ZSTAT: begin
					if (outfree) begin
						kind_q <= mrdo_pkg::KIND_STATUS; ob_q <= '0;
						last_q <= 1'b0; mend_q <= 1'b0; rej_q <= 1'b1; drp_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_PFIRST: begin
					if (need_drop) begin
						state_q <= S_DROP;
					end else begin
						cursor_q <= new_start;
						plen_q   <= UW'(it_q.msg_len);
						left_q   <= LW'(it_q.msg_len);
						state_q  <= S_PBYTE;
					end
				end
				S_DROP: begin
					// head descriptor is on desc_rd_q now
					used_q  <= used_q - d_len;
					head_q  <= head_nx;
					count_q <= count_q - 1'b1;
					flags_q[1] <= 1'b1;
					state_q <= S_PFIRST;
				end
				S_PBYTE: begin
					if (left_q == '0) begin
						state_q <= S_IDLE;
					end else if (left_q != LW'(1)) begin
						if (!flags_q[0]) cursor_q <= cursor_nx;
						left_q  <= left_q - 1'b1;
						state_q <= S_IDLE;
					end else if (outfree) begin
						kind_q <= mrdo_pkg::KIND_STATUS; ob_q <= '0;
						last_q <= 1'b0; mend_q <= 1'b0;
						rej_q <= flags_q[0]; drp_q <= flags_q[1];
						if (!flags_q[0]) begin
							cursor_q <= cursor_nx;
							tail_q   <= cursor_nx;
							count_q  <= count_q + 1'b1;
							used_q   <= used_q + plen_q;
						end
						flags_q <= '0;
						left_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_RHEAD: begin
					state_q <= (count_q == '0) ? S_REND : S_RCHK;
				end
				S_RCHK: begin
					if (rover) begin
						state_q <= S_REND;
					end else if (!pend_q || outfree) begin
						if (pend_q) begin
							kind_q <= mrdo_pkg::KIND_DATA; ob_q <= pbyte_q;
							last_q <= 1'b0; mend_q <= 1'b1; rej_q <= 1'b0; drp_q <= 1'b0;
							pend_q <= 1'b0;
						end
						rcur_q  <= d_start;
						rrem_q  <= d_len;
						total_q <= total_q + TW'(d_len);
						state_q <= S_RBYTE;
					end
				end
				S_RBYTE: begin
					state_q <= S_ROUT;
				end
				S_ROUT: begin
					if (rrem_q == UW'(1)) begin
						// hold the message's final byte until we know if more follows
						pend_q  <= 1'b1;
						pbyte_q <= byte_rd_q;
						head_q  <= head_nx;
						count_q <= count_q - 1'b1;
						used_q  <= used_q - d_len;
						state_q <= S_RHEAD;
					end else if (outfree) begin
						kind_q <= mrdo_pkg::KIND_DATA; ob_q <= byte_rd_q;
						last_q <= 1'b0; mend_q <= 1'b0; rej_q <= 1'b0; drp_q <= 1'b0;
						rcur_q  <= rcur_nx;
						rrem_q  <= rrem_q - 1'b1;
						state_q <= S_RBYTE;
					end
				end
				S_REND: begin
					if (outfree) begin
						last_q <= 1'b1; rej_q <= 1'b0; drp_q <= 1'b0;
						if (pend_q) begin
							kind_q <= mrdo_pkg::KIND_DATA; ob_q <= pbyte_q; mend_q <= 1'b1;
						end else begin
							kind_q <= mrdo_pkg::KIND_NOTHING; ob_q <= '0; mend_q <= 1'b0;
						end
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = ov_q;
	assign kind        = kind_q;
	assign out_byte    = ob_q;
	assign last        = last_q;
	assign message_end = mend_q;
	assign rejected    = rej_q;
	assign dropped     = drp_q;
endmodule
